// ===== hdl/uvs_pkg.sv =====
// uvs_pkg: shared constants, command/status types and the CORDIC arctangent table
// for the UV-sphere wireframe generator. No dependencies.
`timescale 1ns / 1ps

package uvs_pkg;

	// mesh limits and output format
	localparam int MAX_SECTORS     = 256;
	localparam int MAX_STACKS      = 256;
	localparam int MIN_SECTORS     = 3;
	localparam int MIN_STACKS      = 2;
	localparam int COORD_FRAC_BITS = 14;

	// field and register widths
	localparam int CNT_W   = 9;                          // count registers
	localparam int SEC_W   = $clog2(MAX_SECTORS);        // sector position, j < S
	localparam int STK_W   = $clog2(MAX_STACKS + 1);     // stack position, i <= T
	localparam int DEN_W   = CNT_W + 1;                  // divider, holds 2*T
	localparam int VTX_W   = 17;
	localparam int COORD_W = 16;

	// phase and CORDIC arithmetic
	localparam int PHASE_W      = 32;                    // turn fraction, 2^32 = full turn
	localparam int Q_FRAC       = PHASE_W - 2;           // Q30 sin/cos
	localparam int Q30_W        = Q_FRAC + 2;            // signed mapped sin/cos
	localparam int CW           = Q_FRAC + 4;            // CORDIC x/y/z registers
	localparam int CORDIC_ITERS = 24;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);
	localparam int DIV_STEPS    = PHASE_W / 2;           // two quotient bits per step
	localparam int PROD_W       = 2 * Q30_W;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic signed [CW-1:0] CORDIC_ONE  = CW'(1) <<< Q_FRAC;
	localparam logic [PHASE_W-1:0]   QUARTER     = PHASE_W'(1) << (PHASE_W - 2);

	// rounding of Q60 products and the Q30 z term to the output format
	localparam int XY_SH = 2 * Q_FRAC - COORD_FRAC_BITS;
	localparam int Z_SH  = Q_FRAC - COORD_FRAC_BITS;
	localparam logic signed [PROD_W-1:0] HALF_XY = PROD_W'(1) <<< (XY_SH - 1);
	localparam logic signed [PROD_W-1:0] HALF_Z  = PROD_W'(1) <<< (Z_SH - 1);
	localparam logic signed [PROD_W-1:0] SAT_HI  = (PROD_W'(1) <<< (COORD_W - 1)) - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] SAT_LO  = -(PROD_W'(1) <<< (COORD_W - 1));

	// configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STACKS  = 1'b1;
	localparam logic [CNT_W-1:0] SECTORS_RST = CNT_W'(32);
	localparam logic [CNT_W-1:0] STACKS_RST  = CNT_W'(16);

	// controller to datapath
	typedef struct packed {
		logic              accept;
		logic              prep;
		logic              div_step;
		logic              rot_init;
		logic              rot_step;
		logic              map;
		logic              mul;
		logic              load;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

	// atan(2^-k) in turn units (2^32 per turn)
	function automatic logic [Q_FRAC-1:0] turn_atan(input logic [ITER_W-1:0] k);
		logic [Q_FRAC-1:0] a;
		case (k)
			5'd0:    a = Q_FRAC'(536870912);
			5'd1:    a = Q_FRAC'(316933406);
			5'd2:    a = Q_FRAC'(167458907);
			5'd3:    a = Q_FRAC'(85004756);
			5'd4:    a = Q_FRAC'(42667331);
			5'd5:    a = Q_FRAC'(21354465);
			5'd6:    a = Q_FRAC'(10679838);
			5'd7:    a = Q_FRAC'(5340245);
			5'd8:    a = Q_FRAC'(2670163);
			5'd9:    a = Q_FRAC'(1335087);
			5'd10:   a = Q_FRAC'(667544);
			5'd11:   a = Q_FRAC'(333772);
			5'd12:   a = Q_FRAC'(166886);
			5'd13:   a = Q_FRAC'(83443);
			5'd14:   a = Q_FRAC'(41722);
			5'd15:   a = Q_FRAC'(20861);
			5'd16:   a = Q_FRAC'(10430);
			5'd17:   a = Q_FRAC'(5215);
			5'd18:   a = Q_FRAC'(2608);
			5'd19:   a = Q_FRAC'(1304);
			5'd20:   a = Q_FRAC'(652);
			5'd21:   a = Q_FRAC'(326);
			5'd22:   a = Q_FRAC'(163);
			5'd23:   a = Q_FRAC'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/uvs_div.sv =====
// uvs_div: radix-4 restoring divider for turn-fraction phases, num*2^32/den.
// Requires num < den. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_div (
	input  logic                        clk,
	input  logic                        init,
	input  logic                        step,
	input  logic [uvs_pkg::DEN_W-1:0]   num,
	input  logic [uvs_pkg::DEN_W-1:0]   den,
	output logic [uvs_pkg::PHASE_W-1:0] quot
);

	logic [uvs_pkg::DEN_W-1:0]   rem_q;
	logic [uvs_pkg::PHASE_W-1:0] quot_q;
	logic [uvs_pkg::DEN_W:0]     r1, r2, den_x;
	logic [uvs_pkg::DEN_W-1:0]   r1m, r2m;
	logic                        b1, b2;

	// two dependent shift/compare/subtract steps per cycle
	always_comb begin
		den_x = {1'b0, den};
		r1    = {rem_q, 1'b0};
		b1    = (r1 >= den_x);
		r1m   = b1 ? uvs_pkg::DEN_W'(r1 - den_x) : r1[uvs_pkg::DEN_W-1:0];
		r2    = {r1m, 1'b0};
		b2    = (r2 >= den_x);
		r2m   = b2 ? uvs_pkg::DEN_W'(r2 - den_x) : r2[uvs_pkg::DEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q  <= num;
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= r2m;
			quot_q <= {quot_q[uvs_pkg::PHASE_W-3:0], b1, b2};
		end
	end

	assign quot = quot_q;

endmodule

// ===== hdl/uvs_cordic.sv =====
// uvs_cordic: iterative rotation-mode CORDIC, one iteration per cycle, giving
// clamped Q30 cos/sin of a 32-bit turn phase mapped to its quadrant. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_cordic (
	input  logic                              clk,
	input  logic                              init,
	input  logic                              step,
	input  logic [uvs_pkg::ITER_W-1:0]        iter,
	input  logic [uvs_pkg::PHASE_W-1:0]       phase,
	output logic signed [uvs_pkg::Q30_W-1:0]  cos_o,
	output logic signed [uvs_pkg::Q30_W-1:0]  sin_o
);

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	logic signed [uvs_pkg::CW-1:0]    x_q, y_q, z_q;
	quad_t                            quad_q;
	logic signed [uvs_pkg::CW-1:0]    dx, dy, atan_s;
	logic signed [uvs_pkg::Q30_W-1:0] c_cl, s_cl;

	always_comb begin
		dx     = y_q >>> iter;
		dy     = x_q >>> iter;
		atan_s = uvs_pkg::CW'(uvs_pkg::turn_atan(iter));
	end

	always_ff @(posedge clk) begin
		if (init) begin
			x_q    <= uvs_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= uvs_pkg::CW'(phase[uvs_pkg::PHASE_W-3:0]);
			quad_q <= quad_t'(phase[uvs_pkg::PHASE_W-1 -: 2]);
		end else if (step) begin
			if (!z_q[uvs_pkg::CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_s;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_s;
			end
		end
	end

	// clamp to [0, 1.0] in Q30, then rotate by the quadrant
	always_comb begin
		if (x_q < 0)
			c_cl = '0;
		else if (x_q > uvs_pkg::CORDIC_ONE)
			c_cl = uvs_pkg::CORDIC_ONE[uvs_pkg::Q30_W-1:0];
		else
			c_cl = x_q[uvs_pkg::Q30_W-1:0];
		if (y_q < 0)
			s_cl = '0;
		else if (y_q > uvs_pkg::CORDIC_ONE)
			s_cl = uvs_pkg::CORDIC_ONE[uvs_pkg::Q30_W-1:0];
		else
			s_cl = y_q[uvs_pkg::Q30_W-1:0];

		case (quad_q)
			QUAD_I: begin
				cos_o = c_cl;
				sin_o = s_cl;
			end
			QUAD_II: begin
				cos_o = -s_cl;
				sin_o = c_cl;
			end
			QUAD_III: begin
				cos_o = -c_cl;
				sin_o = -s_cl;
			end
			QUAD_IV: begin
				cos_o = s_cl;
				sin_o = -c_cl;
			end
			default: begin
				cos_o = c_cl;
				sin_o = s_cl;
			end
		endcase
	end

endmodule

// ===== hdl/uvs_dp.sv =====
// uvs_dp: datapath - count registers, mesh position, index arithmetic, phase
// dividers, CORDIC lanes, multipliers and the output register. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [uvs_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                restart,
	input  uvs_pkg::cmd_t                       cmd,
	output uvs_pkg::sts_t                       sts,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [uvs_pkg::VTX_W-1:0]           vertex_index,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_x,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_y,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_z,
	output logic                                meridian_edge,
	output logic                                ring_edge,
	output logic [uvs_pkg::VTX_W-1:0]           ring_neighbor,
	output logic                                last_vertex
);

	localparam int CNT_W   = uvs_pkg::CNT_W;
	localparam int SEC_W   = uvs_pkg::SEC_W;
	localparam int STK_W   = uvs_pkg::STK_W;
	localparam int VTX_W   = uvs_pkg::VTX_W;
	localparam int DEN_W   = uvs_pkg::DEN_W;
	localparam int Q30_W   = uvs_pkg::Q30_W;
	localparam int PROD_W  = uvs_pkg::PROD_W;
	localparam int COORD_W = uvs_pkg::COORD_W;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] r);
		logic signed [COORD_W-1:0] o;
		if (r > uvs_pkg::SAT_HI)
			o = {1'b0, {(COORD_W-1){1'b1}}};
		else if (r < uvs_pkg::SAT_LO)
			o = {1'b1, {(COORD_W-1){1'b0}}};
		else
			o = r[COORD_W-1:0];
		return o;
	endfunction

	// configuration and mesh position
	logic [CNT_W-1:0] sector_count_q, stack_count_q;
	logic [CNT_W-1:0] s_sat, t_sat;
	logic [SEC_W-1:0] sec_pos_q;
	logic [STK_W-1:0] stk_pos_q;
	logic             clr;

	// working copy of the vertex being generated
	logic [SEC_W-1:0] jw_q;
	logic [STK_W-1:0] iw_q;
	logic [CNT_W-1:0] s_w_q, t_w_q;
	logic [VTX_W-1:0] t1;
	logic [VTX_W-1:0] v_q, total_q, nb_q;
	logic [VTX_W:0]   nb_sum, nb_wrap;
	logic             merid_q, ring_q, last_q;

	logic [uvs_pkg::PHASE_W-1:0] sec_phase, stk_quot, stk_phase;
	logic signed [Q30_W-1:0]     cs, ss, ct, st;
	logic signed [Q30_W-1:0]     cs_q, ss_q, ct_q, st_q;
	logic signed [PROD_W-1:0]    prod_x_q, prod_y_q;
	logic signed [PROD_W-1:0]    rx, ry, rz;

	logic                      out_valid_q;
	logic [VTX_W-1:0]          vertex_index_q, ring_neighbor_q;
	logic signed [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic                      meridian_edge_q, ring_edge_q, last_vertex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= uvs_pkg::SECTORS_RST;
			stack_count_q  <= uvs_pkg::STACKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				uvs_pkg::CFG_SECTORS: sector_count_q <= cfg_data;
				uvs_pkg::CFG_STACKS:  stack_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sector_count_q < CNT_W'(uvs_pkg::MIN_SECTORS))
			s_sat = CNT_W'(uvs_pkg::MIN_SECTORS);
		else if (sector_count_q > CNT_W'(uvs_pkg::MAX_SECTORS))
			s_sat = CNT_W'(uvs_pkg::MAX_SECTORS);
		else
			s_sat = sector_count_q;
		if (stack_count_q < CNT_W'(uvs_pkg::MIN_STACKS))
			t_sat = CNT_W'(uvs_pkg::MIN_STACKS);
		else if (stack_count_q > CNT_W'(uvs_pkg::MAX_STACKS))
			t_sat = CNT_W'(uvs_pkg::MAX_STACKS);
		else
			t_sat = stack_count_q;
		// held position outside the current mesh restarts it as well
		clr = restart || (CNT_W'(sec_pos_q) >= s_sat) || (CNT_W'(stk_pos_q) > t_sat);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			jw_q  <= clr ? '0 : sec_pos_q;
			iw_q  <= clr ? '0 : stk_pos_q;
			s_w_q <= s_sat;
			t_w_q <= t_sat;
		end
	end

	assign t1 = VTX_W'(t_w_q) + VTX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_pos_q <= '0;
			stk_pos_q <= '0;
		end else if (cmd.prep) begin
			if (CNT_W'(iw_q) >= t_w_q) begin
				stk_pos_q <= '0;
				sec_pos_q <= (CNT_W'(jw_q) + CNT_W'(1) >= s_w_q) ? '0 : SEC_W'(jw_q + SEC_W'(1));
			end else begin
				stk_pos_q <= STK_W'(iw_q + STK_W'(1));
				sec_pos_q <= jw_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			v_q     <= VTX_W'(VTX_W'(jw_q) * t1 + VTX_W'(iw_q));
			total_q <= VTX_W'(VTX_W'(s_w_q) * t1);
			merid_q <= (iw_q != '0);
			ring_q  <= (iw_q != '0) && (CNT_W'(iw_q) < t_w_q);
			last_q  <= (CNT_W'(jw_q) == s_w_q - CNT_W'(1)) && (CNT_W'(iw_q) == t_w_q);
		end
	end

	// ring neighbor wraps around the last sector
	always_comb begin
		nb_sum  = {1'b0, v_q} + {1'b0, t1};
		nb_wrap = (nb_sum >= {1'b0, total_q}) ? nb_sum - {1'b0, total_q} : nb_sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.rot_init)
			nb_q <= nb_wrap[VTX_W-1:0];
	end

	// sector phase j*2^32/S; stack phase 2^30 - i*2^31/T, taken as i*2^32/(2T)
	uvs_div u_div_sec (
		.clk  (clk),
		.init (cmd.prep),
		.step (cmd.div_step),
		.num  (DEN_W'(jw_q)),
		.den  (DEN_W'(s_w_q)),
		.quot (sec_phase)
	);

	uvs_div u_div_stk (
		.clk  (clk),
		.init (cmd.prep),
		.step (cmd.div_step),
		.num  (DEN_W'(iw_q)),
		.den  ({t_w_q, 1'b0}),
		.quot (stk_quot)
	);

	assign stk_phase = uvs_pkg::QUARTER - stk_quot;

	uvs_cordic u_cordic_sec (
		.clk   (clk),
		.init  (cmd.rot_init),
		.step  (cmd.rot_step),
		.iter  (cmd.iter),
		.phase (sec_phase),
		.cos_o (cs),
		.sin_o (ss)
	);

	uvs_cordic u_cordic_stk (
		.clk   (clk),
		.init  (cmd.rot_init),
		.step  (cmd.rot_step),
		.iter  (cmd.iter),
		.phase (stk_phase),
		.cos_o (ct),
		.sin_o (st)
	);

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			cs_q <= cs;
			ss_q <= ss;
			ct_q <= ct;
			st_q <= st;
		end
		if (cmd.mul) begin
			prod_x_q <= PROD_W'(cs_q) * PROD_W'(ct_q);
			prod_y_q <= PROD_W'(ss_q) * PROD_W'(ct_q);
		end
	end

	// round half up, floor shift, saturate
	always_comb begin
		rx = (prod_x_q + uvs_pkg::HALF_XY) >>> uvs_pkg::XY_SH;
		ry = (prod_y_q + uvs_pkg::HALF_XY) >>> uvs_pkg::XY_SH;
		rz = (PROD_W'(st_q) + uvs_pkg::HALF_Z) >>> uvs_pkg::Z_SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vertex_index_q  <= v_q;
			pos_x_q         <= sat_coord(rx);
			pos_y_q         <= sat_coord(ry);
			pos_z_q         <= sat_coord(rz);
			meridian_edge_q <= merid_q;
			ring_edge_q     <= ring_q;
			ring_neighbor_q <= ring_q ? nb_q : '0;
			last_vertex_q   <= last_q;
		end
	end

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign vertex_index  = vertex_index_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign pos_z         = pos_z_q;
	assign meridian_edge = meridian_edge_q;
	assign ring_edge     = ring_edge_q;
	assign ring_neighbor = ring_neighbor_q;
	assign last_vertex   = last_vertex_q;

endmodule

// ===== hdl/uvs_ctrl.sv =====
// uvs_ctrl: sequencing state machine and step counter for one vertex at a time.
// Drives uvs_pkg::cmd_t to the datapath. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  uvs_pkg::sts_t sts,
	output uvs_pkg::cmd_t cmd
);

	localparam int ITER_W = uvs_pkg::ITER_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PREP = 8'b0000_0010,
		ST_DIV  = 8'b0000_0100,
		ST_ROTI = 8'b0000_1000,
		ST_ROT  = 8'b0001_0000,
		ST_MAP  = 8'b0010_0000,
		ST_MUL  = 8'b0100_0000,
		ST_LOAD = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.iter = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == ITER_W'(uvs_pkg::DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_ROTI;
				end else begin
					cnt_d = cnt_q + ITER_W'(1);
				end
			end
			ST_ROTI: begin
				cmd.rot_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (cnt_q == ITER_W'(uvs_pkg::CORDIC_ITERS - 1)) begin
					cnt_d   = '0;
					state_d = ST_MAP;
				end else begin
					cnt_d = cnt_q + ITER_W'(1);
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// wait until the output register is empty or draining
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== hdl/uv_sphere_wireframe_generator.sv =====
// UV-sphere wireframe generator: one vertex per input transfer, position via CORDIC.
// Each vertex runs through operand setup, 16 radix-4 phase divider steps, CORDIC load,
// 24 CORDIC iterations, quadrant map, multiply and round, before the output load.
// One item at a time: no new input until the result loads, which waits on out_stall.
// Reset (arst_n, async): clears control state and mesh position, counts go to 32 / 16.
`timescale 1ns / 1ps

module uv_sphere_wireframe_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [uvs_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [uvs_pkg::VTX_W-1:0]           vertex_index,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_x,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_y,
	output logic signed [uvs_pkg::COORD_W-1:0]  pos_z,
	output logic                                meridian_edge,
	output logic                                ring_edge,
	output logic [uvs_pkg::VTX_W-1:0]           ring_neighbor,
	output logic                                last_vertex
);

	uvs_pkg::cmd_t cmd;
	uvs_pkg::sts_t sts;

	uvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	uvs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.restart       (restart),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.vertex_index  (vertex_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.meridian_edge (meridian_edge),
		.ring_edge     (ring_edge),
		.ring_neighbor (ring_neighbor),
		.last_vertex   (last_vertex)
	);

endmodule

// ===== hdl/uvs_checker.sv =====
// uvs_checker: port-level assertions for the UV-sphere wireframe generator,
// bound to the top level. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [uvs_pkg::VTX_W-1:0]           vertex_index,
	input logic                                meridian_edge,
	input logic                                ring_edge,
	input logic [uvs_pkg::VTX_W-1:0]           ring_neighbor,
	input logic                                last_vertex
);

	// a stalled result is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one vertex in flight: no input transfer right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a vertex is in work");

	a_nb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ring_edge |-> ring_neighbor == '0)
		else $error("ring neighbor nonzero without ring edge");

	// at least three sectors, so the neighbor is never the vertex itself
	a_nb_other: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ring_edge |-> ring_neighbor != vertex_index)
		else $error("ring edge points at its own vertex");

	// the final vertex is a pole: meridian edge but no ring edge
	a_last_pole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_vertex |-> meridian_edge && !ring_edge)
		else $error("last vertex edge flags inconsistent");

endmodule

bind uv_sphere_wireframe_generator uvs_checker u_uvs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.vertex_index  (vertex_index),
	.meridian_edge (meridian_edge),
	.ring_edge     (ring_edge),
	.ring_neighbor (ring_neighbor),
	.last_vertex   (last_vertex)
);
